// ===== sv/sar_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment alignment range - shared package
// Widths, codes, table row layouts and the walk command that passes between
// the operand stages and the walk unit.
// ----------------------------------------------------------------------------
package sar_pkg;

	// table sizing
	localparam int MAX_SEG    = 64;
	localparam int SEG_AW     = $clog2(MAX_SEG);
	localparam int LOOP_DEPTH = MAX_SEG + 1;
	localparam int LOOP_AW    = $clog2(LOOP_DEPTH);

	// field widths
	localparam int IDX_W      = 7;
	localparam int SEQ_W      = 16;
	localparam int OFF_W      = 10;
	localparam int LEN_W      = 12;
	localparam int POS_W      = 17;
	localparam int RES_W      = 18;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// walk accumulators: wide enough for every exact sum over a full table
	localparam int ACC_W      = 21;
	localparam int RES_MAX    = 2 ** (RES_W - 1) - 1;
	localparam int RES_MIN    = -(2 ** (RES_W - 1));

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 1'b1;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [OFF_W-1:0]        n_off;
		logic [OFF_W-1:0]        c_off;
		logic signed [POS_W-1:0] cons_lo;
		logic signed [POS_W-1:0] cons_hi;
		logic signed [POS_W-1:0] aligned;
	} seg_row_t;

	typedef struct packed {
		logic [LEN_W-1:0] cur;
		logic [LEN_W-1:0] lo;
		logic [LEN_W-1:0] hi;
	} loop_row_t;

	// what a table read is for
	typedef enum logic [2:0] {
		TAG_LOOP0,   // n-terminal loop: start of forward walk
		TAG_FWD,     // segment before the queried one
		TAG_SEGCS,   // the queried segment: close forward walk
		TAG_LOOPN,   // c-terminal tail: start of reverse walk
		TAG_REV,     // segment after the queried one
		TAG_REVEND   // close reverse walk, no read
	} tag_t;

	typedef struct packed {
		logic valid;
		tag_t tag;
	} issue_t;

	// one step for the walk unit
	typedef struct packed {
		logic valid;
		logic load;
		logic save;
		logic last;
		logic snap;
		logic has_lo;
		logic has_hi;
		acc_t k_lo;
		acc_t k_hi;
		acc_t b_lo;
		acc_t b_hi;
		acc_t s_lo;
		acc_t s_hi;
	} walk_cmd_t;

	function automatic acc_t ext_off(input logic [OFF_W-1:0] v);
		return $signed({{(ACC_W - OFF_W){1'b0}}, v});
	endfunction

	function automatic acc_t ext_len(input logic [LEN_W-1:0] v);
		return $signed({{(ACC_W - LEN_W){1'b0}}, v});
	endfunction

	function automatic acc_t ext_seq(input logic [SEQ_W-1:0] v);
		return $signed({{(ACC_W - SEQ_W){1'b0}}, v});
	endfunction

	function automatic acc_t ext_pos(input logic signed [POS_W-1:0] v);
		return $signed({{(ACC_W - POS_W){v[POS_W-1]}}, v});
	endfunction

endpackage

// ===== sv/sar_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module sar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sar_prep.sv =====
// ----------------------------------------------------------------------------
// Segment alignment range - operand stages
// Turns one table read into one walk step over two register stages: first
// the per-row sums, then the loop length folded into every operand.
// ----------------------------------------------------------------------------
module sar_prep import sar_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  issue_t           iss_s1,
	input  seg_row_t         seg_rd,
	input  loop_row_t        loop_rd,
	input  logic [SEQ_W-1:0] seq_len,
	output walk_cmd_t        cmd,
	output seg_row_t         cs_row
);

	acc_t n_a, c_a, cl_a, ch_a, al_a, seq_a, llo_a, ml_a, mh_a, sl_a;
	acc_t ksl_d, bl_d, bh_d, sn_d, mlo_d, mhi_d;
	logic has_lo_d, has_hi_d, snap_d;

	logic v_s2;
	tag_t tag_s2;
	acc_t ksl_s2, bl_s2, bh_s2, sn_s2, mlo_s2, mhi_s2;
	logic has_lo_s2, has_hi_s2, snap_s2;

	seg_row_t  cs_row_q;
	logic      cmd_v_q;
	walk_cmd_t cmd_q;

	// row operands
	always_comb begin
		n_a   = ext_off(seg_rd.n_off);
		c_a   = ext_off(seg_rd.c_off);
		cl_a  = ext_pos(seg_rd.cons_lo);
		ch_a  = ext_pos(seg_rd.cons_hi);
		al_a  = ext_pos(seg_rd.aligned);
		seq_a = ext_seq(seq_len);
		llo_a = ext_len(loop_rd.lo);
		ml_a  = ext_len((loop_rd.cur > loop_rd.lo) ? loop_rd.cur : loop_rd.lo);
		mh_a  = ext_len((loop_rd.cur > loop_rd.hi) ? loop_rd.cur : loop_rd.hi);
		sl_a  = n_a + c_a + acc_t'(1);
	end

	// first stage: per-tag sums; reverse steps carry negated loop lengths
	always_comb begin
		ksl_d    = '0;
		bl_d     = '0;
		bh_d     = '0;
		sn_d     = '0;
		mlo_d    = '0;
		mhi_d    = '0;
		has_lo_d = 1'b0;
		has_hi_d = 1'b0;
		snap_d   = 1'b0;
		case (iss_s1.tag)
			TAG_LOOP0: begin
				bl_d = llo_a - acc_t'(1);
				bh_d = seq_a;
			end
			TAG_FWD: begin
				ksl_d    = sl_a;
				bl_d     = cl_a + c_a;
				bh_d     = ch_a + c_a;
				sn_d     = al_a + c_a;
				mlo_d    = ml_a;
				mhi_d    = mh_a;
				has_lo_d = !seg_rd.cons_lo[POS_W-1] && (seg_rd.cons_lo != '0);
				has_hi_d = !seg_rd.cons_hi[POS_W-1] && (seg_rd.cons_hi != '0);
				snap_d   = !seg_rd.aligned[POS_W-1];
			end
			TAG_SEGCS: begin
				ksl_d = n_a + acc_t'(1);
			end
			TAG_LOOPN: begin
				bl_d = acc_t'(-1);
				bh_d = seq_a - llo_a;
			end
			TAG_REV: begin
				ksl_d    = -sl_a;
				bl_d     = cl_a - n_a;
				bh_d     = ch_a - n_a;
				sn_d     = al_a - n_a;
				mlo_d    = -mh_a;
				mhi_d    = -ml_a;
				has_lo_d = !seg_rd.cons_lo[POS_W-1] && (seg_rd.cons_lo != '0);
				has_hi_d = !seg_rd.cons_hi[POS_W-1] && (seg_rd.cons_hi != '0);
				snap_d   = !seg_rd.aligned[POS_W-1];
			end
			TAG_REVEND: begin
				ksl_d = -(ext_off(cs_row_q.c_off) + acc_t'(1));
			end
			default: begin
			end
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			cmd_v_q <= 1'b0;
		end else begin
			v_s2    <= iss_s1.valid;
			cmd_v_q <= v_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		tag_s2    <= iss_s1.tag;
		ksl_s2    <= ksl_d;
		bl_s2     <= bl_d;
		bh_s2     <= bh_d;
		sn_s2     <= sn_d;
		mlo_s2    <= mlo_d;
		mhi_s2    <= mhi_d;
		has_lo_s2 <= has_lo_d;
		has_hi_s2 <= has_hi_d;
		snap_s2   <= snap_d;
		if (iss_s1.valid && (iss_s1.tag == TAG_SEGCS)) begin
			cs_row_q <= seg_rd;
		end

		// second stage: fold the loop length into each operand
		cmd_q.valid  <= v_s2;
		cmd_q.load   <= (tag_s2 == TAG_LOOP0) || (tag_s2 == TAG_LOOPN);
		cmd_q.save   <= (tag_s2 == TAG_LOOPN);
		cmd_q.last   <= (tag_s2 == TAG_REVEND);
		cmd_q.snap   <= snap_s2;
		cmd_q.has_lo <= has_lo_s2;
		cmd_q.has_hi <= has_hi_s2;
		cmd_q.k_lo   <= ksl_s2 + mlo_s2;
		cmd_q.k_hi   <= ksl_s2 + mhi_s2;
		cmd_q.b_lo   <= bl_s2 + mlo_s2;
		cmd_q.b_hi   <= bh_s2 + mhi_s2;
		cmd_q.s_lo   <= sn_s2 + mlo_s2;
		cmd_q.s_hi   <= sn_s2 + mhi_s2;
	end

	always_comb begin
		cmd       = cmd_q;
		cmd.valid = cmd_v_q;
	end

	assign cs_row = cs_row_q;

endmodule

// ===== sv/sar_walk.sv =====
// ----------------------------------------------------------------------------
// Segment alignment range - walk unit
// The shared step: add, clamp against a bound, or snap to an aligned
// position, on the low and high end accumulators. Serves both walks.
// ----------------------------------------------------------------------------
module sar_walk import sar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  walk_cmd_t cmd,
	output acc_t      acc_lo,
	output acc_t      acc_hi,
	output acc_t      nt_lo,
	output acc_t      nt_hi,
	output logic      done
);

	acc_t acc_lo_q, acc_hi_q, nt_lo_q, nt_hi_q;
	acc_t t_lo, t_hi, lo_step, hi_step;
	logic done_q;

	// one step: low end clamps upwards, high end downwards
	always_comb begin
		t_lo = acc_lo_q + cmd.k_lo;
		t_hi = acc_hi_q + cmd.k_hi;
		if (cmd.snap) begin
			lo_step = cmd.s_lo;
		end else if (cmd.has_lo && (cmd.b_lo > t_lo)) begin
			lo_step = cmd.b_lo;
		end else begin
			lo_step = t_lo;
		end
		if (cmd.snap) begin
			hi_step = cmd.s_hi;
		end else if (cmd.has_hi && (cmd.b_hi < t_hi)) begin
			hi_step = cmd.b_hi;
		end else begin
			hi_step = t_hi;
		end
	end

	// accumulators; a saving load parks the forward result
	always_ff @(posedge clk) begin
		if (cmd.valid) begin
			if (cmd.load) begin
				if (cmd.save) begin
					nt_lo_q <= acc_lo_q;
					nt_hi_q <= acc_hi_q;
				end
				acc_lo_q <= cmd.b_lo;
				acc_hi_q <= cmd.b_hi;
			end else begin
				acc_lo_q <= lo_step;
				acc_hi_q <= hi_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.valid && cmd.last;
		end
	end

	assign acc_lo = acc_lo_q;
	assign acc_hi = acc_hi_q;
	assign nt_lo  = nt_lo_q;
	assign nt_hi  = nt_hi_q;
	assign done   = done_q;

endmodule

// ===== sv/segment_alignment_range.sv =====
// ----------------------------------------------------------------------------
// Segment alignment range - top level
// Segment and loop tables, query sequencer, range intersection and the
// registered result beat.
// ----------------------------------------------------------------------------
// A write beat fills the segment row (index below MAX_SEG) and the loop row
// (index up to MAX_SEG) of its index and gives no result. During a query
// beat for segment s the sequencer reads one table row per cycle through the
// single read port of each table, and the walk unit retires one segment per
// cycle, forward over segments 0..s-1 and then backward from the tail down to
// s+1, followed by the pipeline drain in ST_WAIT, range intersection in
// ST_FIN1 to ST_FIN3 and the result load in ST_OUT. A query for a segment at
// or beyond the effective segment count goes straight to ST_OUT and answers
// with valid_res low. Input is stalled for the whole query; a result
// may wait on out_stall while the next beat is accepted. Table rows that were
// never written read back as anything.
// ----------------------------------------------------------------------------
module segment_alignment_range import sar_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  logic [IDX_W-1:0]        index,
	input  logic [OFF_W-1:0]        n_offset,
	input  logic [OFF_W-1:0]        c_offset,
	input  logic [LEN_W-1:0]        loop_length,
	input  logic [LEN_W-1:0]        loop_min,
	input  logic [LEN_W-1:0]        loop_max,
	input  logic signed [POS_W-1:0] constraint_min,
	input  logic signed [POS_W-1:0] constraint_max,
	input  logic signed [POS_W-1:0] aligned_pos,
	// output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    valid_res,
	output logic signed [RES_W-1:0] min_pos,
	output logic signed [RES_W-1:0] max_pos
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOP0,
		ST_FWD,
		ST_LOOPN,
		ST_REV,
		ST_WAIT,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [SEQ_W-1:0] seq_len_q;
	logic [IDX_W-1:0] seg_cnt_q, nsc, cnt_q, cs_q;
	logic fail_q;
	acc_t rmn_q, rmx_q;
	logic out_valid_q, valid_res_q;
	logic signed [RES_W-1:0] min_pos_q, max_pos_q;

	logic in_acc, wr_beat, qry_beat, seg_we, loop_we;
	seg_row_t  seg_wdata, seg_rd, cs_row;
	loop_row_t loop_wdata, loop_rd;
	logic [SEG_AW-1:0]  seg_raddr;
	logic [LOOP_AW-1:0] loop_raddr;
	issue_t iss_d, iss_s1;
	walk_cmd_t cmd;
	acc_t ct_lo, ct_hi, nt_lo, nt_hi, cl_a, ch_a;
	logic walk_done;

	function automatic logic signed [RES_W-1:0] sat_res(input acc_t v);
		if (v > acc_t'(RES_MAX)) begin
			return RES_W'(RES_MAX);
		end else if (v < acc_t'(RES_MIN)) begin
			return RES_W'(RES_MIN);
		end else begin
			return v[RES_W-1:0];
		end
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= '0;
			seg_cnt_q <= IDX_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEQ_LENGTH:    seq_len_q <= cfg_data[SEQ_W-1:0];
				CFG_SEGMENT_COUNT: seg_cnt_q <= cfg_data[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign nsc = (seg_cnt_q > IDX_W'(MAX_SEG)) ? IDX_W'(MAX_SEG) : seg_cnt_q;

	// input beat decode and table writes
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign wr_beat  = in_acc && (operation == OP_WRITE);
	assign qry_beat = in_acc && (operation == OP_QUERY);
	assign seg_we   = wr_beat && (index < IDX_W'(MAX_SEG));
	assign loop_we  = wr_beat && (index <= IDX_W'(MAX_SEG));

	always_comb begin
		seg_wdata.n_off   = n_offset;
		seg_wdata.c_off   = c_offset;
		seg_wdata.cons_lo = constraint_min;
		seg_wdata.cons_hi = constraint_max;
		seg_wdata.aligned = aligned_pos;
		loop_wdata.cur    = loop_length;
		loop_wdata.lo     = loop_min;
		loop_wdata.hi     = loop_max;
	end

	sar_ram #(
		.WIDTH ($bits(seg_row_t)),
		.DEPTH (MAX_SEG)
	) u_seg_ram (
		.clk   (clk),
		.we    (seg_we),
		.waddr (SEG_AW'(index)),
		.wdata (seg_wdata),
		.raddr (seg_raddr),
		.rdata (seg_rd)
	);

	sar_ram #(
		.WIDTH ($bits(loop_row_t)),
		.DEPTH (LOOP_DEPTH)
	) u_loop_ram (
		.clk   (clk),
		.we    (loop_we),
		.waddr (LOOP_AW'(index)),
		.wdata (loop_wdata),
		.raddr (loop_raddr),
		.rdata (loop_rd)
	);

	// read issue: one row per cycle, tagged with its use
	always_comb begin
		iss_d.valid = 1'b0;
		iss_d.tag   = TAG_FWD;
		seg_raddr   = SEG_AW'(cnt_q);
		loop_raddr  = LOOP_AW'(cnt_q);
		case (state_q)
			ST_LOOP0: begin
				iss_d.valid = 1'b1;
				iss_d.tag   = TAG_LOOP0;
				loop_raddr  = '0;
			end
			ST_FWD: begin
				iss_d.valid = 1'b1;
				if (cnt_q == cs_q) begin
					iss_d.tag = TAG_SEGCS;
					seg_raddr = SEG_AW'(cs_q);
				end else begin
					iss_d.tag  = TAG_FWD;
					loop_raddr = LOOP_AW'(cnt_q + IDX_W'(1));
				end
			end
			ST_LOOPN: begin
				iss_d.valid = 1'b1;
				iss_d.tag   = TAG_LOOPN;
				loop_raddr  = LOOP_AW'(nsc);
			end
			ST_REV: begin
				iss_d.valid = 1'b1;
				iss_d.tag   = (cnt_q == cs_q) ? TAG_REVEND : TAG_REV;
			end
			default: begin
			end
		endcase
	end

	// issue tag lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1.valid <= 1'b0;
			iss_s1.tag   <= TAG_LOOP0;
		end else begin
			iss_s1 <= iss_d;
		end
	end

	sar_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.iss_s1  (iss_s1),
		.seg_rd  (seg_rd),
		.loop_rd (loop_rd),
		.seq_len (seq_len_q),
		.cmd     (cmd),
		.cs_row  (cs_row)
	);

	sar_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.acc_lo (ct_lo),
		.acc_hi (ct_hi),
		.nt_lo  (nt_lo),
		.nt_hi  (nt_hi),
		.done   (walk_done)
	);

	assign cl_a = ext_pos(cs_row.cons_lo);
	assign ch_a = ext_pos(cs_row.cons_hi);

	// sequencer, intersection and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cs_q        <= '0;
			fail_q      <= 1'b0;
			rmn_q       <= '0;
			rmx_q       <= '0;
			out_valid_q <= 1'b0;
			valid_res_q <= 1'b0;
			min_pos_q   <= '0;
			max_pos_q   <= '0;
		end else begin
			// the result state reloads the beat itself
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (qry_beat) begin
						cs_q   <= index;
						cnt_q  <= '0;
						fail_q <= !(index < nsc);
						state_q <= (index < nsc) ? ST_LOOP0 : ST_OUT;
					end
				end
				ST_LOOP0: begin
					state_q <= ST_FWD;
				end
				ST_FWD: begin
					if (cnt_q == cs_q) begin
						state_q <= ST_LOOPN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_LOOPN: begin
					cnt_q   <= nsc - IDX_W'(1);
					state_q <= ST_REV;
				end
				ST_REV: begin
					if (cnt_q == cs_q) begin
						state_q <= ST_WAIT;
					end else begin
						cnt_q <= cnt_q - IDX_W'(1);
					end
				end
				ST_WAIT: begin
					if (walk_done) begin
						state_q <= ST_FIN1;
					end
				end
				ST_FIN1: begin
					// overlap of the two walk ranges
					fail_q  <= (nt_lo > ct_hi) || (nt_hi < ct_lo);
					rmn_q   <= (nt_lo > ct_lo) ? nt_lo : ct_lo;
					rmx_q   <= (nt_hi < ct_hi) ? nt_hi : ct_hi;
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					// own lower constraint
					if (!cs_row.cons_lo[POS_W-1]) begin
						if (cl_a > rmx_q) begin
							fail_q <= 1'b1;
						end
						if (cl_a > rmn_q) begin
							rmn_q <= cl_a;
						end
					end
					state_q <= ST_FIN3;
				end
				ST_FIN3: begin
					// own upper constraint
					if (!cs_row.cons_hi[POS_W-1]) begin
						if (ch_a < rmn_q) begin
							fail_q <= 1'b1;
						end
						if (ch_a < rmx_q) begin
							rmx_q <= ch_a;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						valid_res_q <= !fail_q;
						min_pos_q   <= fail_q ? '0 : sat_res(rmn_q);
						max_pos_q   <= fail_q ? '0 : sat_res(rmx_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign min_pos   = min_pos_q;
	assign max_pos   = max_pos_q;

	// checks
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> ((min_pos == '0) && (max_pos == '0)))
		else $error("infeasible result carries a non-zero range");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |-> (state_q == ST_WAIT))
		else $error("walk finished outside the wait state");

	a_fwd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FWD) |-> ((cnt_q <= cs_q) && (cs_q < nsc)))
		else $error("forward walk index out of range");

	a_rev_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REV) |-> ((cnt_q >= cs_q) && (cnt_q < nsc)))
		else $error("reverse walk index out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && out_valid && out_stall) |=> (state_q == ST_OUT))
		else $error("result dropped while the output beat is stalled");

endmodule

// ===== bench/tb_segment_alignment_range.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment alignment range - self-checking bench
// Fills the segment and loop tables, runs a short list of hand-picked beats
// (register extremes, ignored writes, unused segments, zero-valued own
// constraints, aligned segments), then random phases of write and query beats
// under several register settings. Each query result is checked against a
// behavioural range calculator kept inside the bench, or against values typed
// in for some hand-picked beats. Both channels are throttled at random.
// ----------------------------------------------------------------------------
module tb_segment_alignment_range;
	import sar_pkg::*;

	localparam int SETTLE    = MAX_SEG + 20;  // cycles for the longest query to drain
	localparam int WATCHDOG  = 4000;          // cycles with no beat on either side
	localparam int NUM_DIR   = 31;
	localparam int PHASES    = 8;
	localparam int PHASE_LEN = 64;
	localparam int HOLD_LEN  = 400;

	// receiver stall styles
	localparam int STALL_NONE = 0;
	localparam int STALL_HALF = 1;
	localparam int STALL_MOST = 2;
	localparam int STALL_RARE = 3;

	typedef struct packed {
		logic                    op;
		logic [IDX_W-1:0]        idx;
		logic [OFF_W-1:0]        n_off;
		logic [OFF_W-1:0]        c_off;
		logic [LEN_W-1:0]        len;
		logic [LEN_W-1:0]        lmin;
		logic [LEN_W-1:0]        lmax;
		logic signed [POS_W-1:0] cmin;
		logic signed [POS_W-1:0] cmax;
		logic signed [POS_W-1:0] apos;
	} beat_t;

	typedef struct packed {
		logic                    ok;
		logic signed [RES_W-1:0] lo;
		logic signed [RES_W-1:0] hi;
	} range_t;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  known;
		range_t                want;
		beat_t                 b;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    operation;
	logic [IDX_W-1:0]        index;
	logic [OFF_W-1:0]        n_offset;
	logic [OFF_W-1:0]        c_offset;
	logic [LEN_W-1:0]        loop_length;
	logic [LEN_W-1:0]        loop_min;
	logic [LEN_W-1:0]        loop_max;
	logic signed [POS_W-1:0] constraint_min;
	logic signed [POS_W-1:0] constraint_max;
	logic signed [POS_W-1:0] aligned_pos;
	logic                    out_valid;
	logic                    out_stall;
	logic                    valid_res;
	logic signed [RES_W-1:0] min_pos;
	logic signed [RES_W-1:0] max_pos;

	// bench copy of the block's tables and registers
	logic [OFF_W-1:0]        n_off_tab   [MAX_SEG];
	logic [OFF_W-1:0]        c_off_tab   [MAX_SEG];
	logic signed [POS_W-1:0] cons_lo_tab [MAX_SEG];
	logic signed [POS_W-1:0] cons_hi_tab [MAX_SEG];
	logic signed [POS_W-1:0] align_tab   [MAX_SEG];
	logic [LEN_W-1:0]        loop_cur_tab[LOOP_DEPTH];
	logic [LEN_W-1:0]        loop_lo_tab [LOOP_DEPTH];
	logic [LEN_W-1:0]        loop_hi_tab [LOOP_DEPTH];
	logic [SEQ_W-1:0]        seq_len_reg;
	logic [IDX_W-1:0]        seg_count_reg;

	range_t   expected_ranges[$];
	dir_row_t directed_rows[NUM_DIR];
	int       fail_count  = 0;
	int       burst_left  = 0;
	int       hold_req    = 0;
	int       idle_cycles = 0;

	segment_alignment_range dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.index          (index),
		.n_offset       (n_offset),
		.c_offset       (c_offset),
		.loop_length    (loop_length),
		.loop_min       (loop_min),
		.loop_max       (loop_max),
		.constraint_min (constraint_min),
		.constraint_max (constraint_max),
		.aligned_pos    (aligned_pos),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.valid_res      (valid_res),
		.min_pos        (min_pos),
		.max_pos        (max_pos)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint larger(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint smaller(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [RES_W-1:0] clamp_res(longint v);
		if (v > RES_MAX) return RES_W'(RES_MAX);
		if (v < RES_MIN) return RES_W'(RES_MIN);
		return RES_W'(v);
	endfunction

	// allowed alignment range of segment cs under the current tables
	function automatic range_t predict_range(int cs);
		int     nsc;
		longint ntmn, ntmx, ctmn, ctmx, sl, rmn, rmx;
		range_t r;
		r = '0;
		nsc = (seg_count_reg > MAX_SEG) ? MAX_SEG : int'(seg_count_reg);
		if (cs >= nsc) return r;

		// forward walk: where the segments before cs can end
		ntmn = longint'(loop_lo_tab[0]) - 1;
		ntmx = longint'(seq_len_reg);
		for (int i = 0; i < cs; i++) begin
			sl = longint'(n_off_tab[i]) + longint'(c_off_tab[i]) + 1;
			ntmn += sl;
			ntmx += sl;
			if (cons_lo_tab[i] > 0)
				ntmn = larger(ntmn, longint'(cons_lo_tab[i]) + longint'(c_off_tab[i]));
			if (cons_hi_tab[i] > 0)
				ntmx = smaller(ntmx, longint'(cons_hi_tab[i]) + longint'(c_off_tab[i]));
			if (align_tab[i] >= 0) begin
				ntmn = longint'(align_tab[i]) + longint'(c_off_tab[i]);
				ntmx = ntmn;
			end
			ntmn += larger(longint'(loop_cur_tab[i + 1]), longint'(loop_lo_tab[i + 1]));
			ntmx += larger(longint'(loop_cur_tab[i + 1]), longint'(loop_hi_tab[i + 1]));
		end
		ntmn += longint'(n_off_tab[cs]) + 1;
		ntmx += longint'(n_off_tab[cs]) + 1;

		// reverse walk from the tail: where the segments after cs can start
		ctmx = longint'(seq_len_reg) - longint'(loop_lo_tab[nsc]);
		ctmn = -1;
		for (int i = nsc - 1; i > cs; i--) begin
			sl = longint'(n_off_tab[i]) + longint'(c_off_tab[i]) + 1;
			ctmn -= sl;
			ctmx -= sl;
			if (cons_lo_tab[i] > 0)
				ctmn = larger(ctmn, longint'(cons_lo_tab[i]) - longint'(n_off_tab[i]));
			if (cons_hi_tab[i] > 0)
				ctmx = smaller(ctmx, longint'(cons_hi_tab[i]) - longint'(n_off_tab[i]));
			if (align_tab[i] >= 0) begin
				ctmn = longint'(align_tab[i]) - longint'(n_off_tab[i]);
				ctmx = ctmn;
			end
			ctmx -= larger(longint'(loop_cur_tab[i]), longint'(loop_lo_tab[i]));
			ctmn -= larger(longint'(loop_cur_tab[i]), longint'(loop_hi_tab[i]));
		end
		ctmn -= longint'(c_off_tab[cs]) + 1;
		ctmx -= longint'(c_off_tab[cs]) + 1;

		// intersect, then apply the segment's own limits (zero counts here)
		if (ntmn > ctmx || ntmx < ctmn) return r;
		rmn = larger(ntmn, ctmn);
		rmx = smaller(ntmx, ctmx);
		if (cons_lo_tab[cs] >= 0) begin
			if (longint'(cons_lo_tab[cs]) > rmx) return r;
			rmn = larger(rmn, longint'(cons_lo_tab[cs]));
		end
		if (cons_hi_tab[cs] >= 0) begin
			if (longint'(cons_hi_tab[cs]) < rmn) return r;
			rmx = smaller(rmx, longint'(cons_hi_tab[cs]));
		end
		r.ok = 1'b1;
		r.lo = clamp_res(rmn);
		r.hi = clamp_res(rmx);
		return r;
	endfunction

	function automatic void record_write(beat_t b);
		if (b.idx < MAX_SEG) begin
			n_off_tab[b.idx]   = b.n_off;
			c_off_tab[b.idx]   = b.c_off;
			cons_lo_tab[b.idx] = b.cmin;
			cons_hi_tab[b.idx] = b.cmax;
			align_tab[b.idx]   = b.apos;
		end
		if (b.idx <= MAX_SEG) begin
			loop_cur_tab[b.idx] = b.len;
			loop_lo_tab[b.idx]  = b.lmin;
			loop_hi_tab[b.idx]  = b.lmax;
		end
	endfunction

	// -------- stimulus builders --------
	function automatic beat_t wr_beat(int idx, int n, int c, int len, int lmin, int lmax,
			int cmin, int cmax, int apos);
		beat_t b;
		b.op    = OP_WRITE;
		b.idx   = IDX_W'(idx);
		b.n_off = OFF_W'(n);
		b.c_off = OFF_W'(c);
		b.len   = LEN_W'(len);
		b.lmin  = LEN_W'(lmin);
		b.lmax  = LEN_W'(lmax);
		b.cmin  = POS_W'(cmin);
		b.cmax  = POS_W'(cmax);
		b.apos  = POS_W'(apos);
		return b;
	endfunction

	function automatic beat_t qry_beat(int idx);
		beat_t b;
		b     = '0;
		b.op  = OP_QUERY;
		b.idx = IDX_W'(idx);
		return b;
	endfunction

	function automatic dir_row_t beat_row(beat_t b);
		dir_row_t r;
		r   = '0;
		r.b = b;
		return r;
	endfunction

	function automatic dir_row_t known_row(beat_t b, logic ok, int lo, int hi);
		dir_row_t r;
		r         = beat_row(b);
		r.known   = 1'b1;
		r.want.ok = ok;
		r.want.lo = RES_W'(lo);
		r.want.hi = RES_W'(hi);
		return r;
	endfunction

	function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] sel, int val);
		dir_row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.reg_sel = sel;
		r.reg_val = CFG_DATA_W'(val);
		return r;
	endfunction

	// constraint: mostly none, sometimes exactly zero, else a position
	function automatic int pick_cons(int seq);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return -1;
		if (r == 6) return 0;
		return $urandom_range(0, seq);
	endfunction

	// table entry: short segments and loops that tend to fit, with some noise
	function automatic beat_t gen_entry(int idx);
		beat_t b;
		int    seq;
		seq   = int'(seq_len_reg);
		b.op  = OP_WRITE;
		b.idx = IDX_W'(idx);
		if ($urandom_range(0, 9) == 0) begin
			b.n_off = OFF_W'($urandom_range(0, 1023));
			b.c_off = OFF_W'($urandom_range(0, 1023));
			b.len   = LEN_W'($urandom_range(0, 4095));
			b.lmin  = LEN_W'($urandom_range(0, 4095));
			b.lmax  = LEN_W'($urandom_range(0, 4095));
			b.cmin  = POS_W'(int'($urandom_range(0, 65536)) - 1);
			b.cmax  = POS_W'(int'($urandom_range(0, 65536)) - 1);
			b.apos  = POS_W'(int'($urandom_range(0, 65536)) - 1);
		end else begin
			b.n_off = OFF_W'($urandom_range(0, 12));
			b.c_off = OFF_W'($urandom_range(0, 12));
			b.lmin  = LEN_W'($urandom_range(0, 8));
			b.len   = LEN_W'($urandom_range(0, 16));
			b.lmax  = LEN_W'(int'(b.lmin) + int'($urandom_range(0, 40)));
			b.cmin  = POS_W'(pick_cons(seq));
			b.cmax  = POS_W'(pick_cons(seq));
			b.apos  = POS_W'(($urandom_range(0, 6) == 0) ? int'($urandom_range(0, seq)) : -1);
		end
		return b;
	endfunction

	function automatic beat_t gen_beat(int nsc);
		beat_t b;
		if ($urandom_range(0, 99) < 45) begin
			b = gen_entry(($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 127))
			                                           : int'($urandom_range(0, nsc)));
		end else begin
			// payload of a query is don't-care, keep it random
			b     = gen_entry(0);
			b.op  = OP_QUERY;
			b.idx = IDX_W'((nsc == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
			                                                       : $urandom_range(0, nsc - 1));
		end
		return b;
	endfunction

	// -------- input channel --------
	task automatic offer(beat_t b);
		@(negedge clk);
		in_valid       = 1'b1;
		operation      = b.op;
		index          = b.idx;
		n_offset       = b.n_off;
		c_offset       = b.c_off;
		loop_length    = b.len;
		loop_min       = b.lmin;
		loop_max       = b.lmax;
		constraint_min = b.cmin;
		constraint_max = b.cmax;
		aligned_pos    = b.apos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic issue(beat_t b, logic known, range_t want);
		offer(b);
		if (b.op == OP_QUERY)
			expected_ranges.push_back(known ? want : predict_range(int'(b.idx)));
		else
			record_write(b);
	endtask

	// bursts of random length separated by short gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		while (expected_ranges.size() != 0) @(posedge clk);
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		drain();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] sel, int val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = sel;
		cfg_data  = CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we = 1'b0;
		if (sel == CFG_SEQ_LENGTH)
			seq_len_reg = SEQ_W'(val);
		else
			seg_count_reg = IDX_W'(val);
	endtask

	// -------- output channel --------
	initial begin : result_stall
		int style, left, hold_left;
		style     = STALL_NONE;
		left      = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (left == 0) begin
				style = $urandom_range(STALL_NONE, STALL_RARE);
				left  = $urandom_range(20, 200);
			end else begin
				left--;
			end
			if (hold_left != 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				case (style)
					STALL_NONE: out_stall = 1'b0;
					STALL_HALF: out_stall = 1'($urandom_range(0, 1));
					STALL_MOST: out_stall = ($urandom_range(0, 3) != 0);
					default:    out_stall = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	task automatic check_field(string name, logic signed [RES_W-1:0] want,
			logic signed [RES_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		range_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ranges.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				want = expected_ranges.pop_front();
				check_field("valid_res", RES_W'(want.ok), RES_W'(valid_res));
				check_field("min_pos", want.lo, min_pos);
				check_field("max_pos", want.hi, max_pos);
			end
		end
	end

	// no beat on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// -------- main sequence --------
	initial begin : stimulus
		int nsc;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_SEQ_LENGTH;
		cfg_data       = '0;
		in_valid       = 1'b0;
		operation      = OP_WRITE;
		index          = '0;
		n_offset       = '0;
		c_offset       = '0;
		loop_length    = '0;
		loop_min       = '0;
		loop_max       = '0;
		constraint_min = '0;
		constraint_max = '0;
		aligned_pos    = '0;
		seq_len_reg    = '0;
		seg_count_reg  = IDX_W'(1);

		// hand-picked beats; expected values typed in only where obvious
		directed_rows[0]  = known_row(qry_beat(1), 1'b0, 0, 0);      // unused segment
		directed_rows[1]  = known_row(qry_beat(127), 1'b0, 0, 0);
		directed_rows[2]  = beat_row(wr_beat(0, 0, 0, 0, 0, 0, -1, -1, -1));
		directed_rows[3]  = beat_row(wr_beat(1, 0, 0, 0, 0, 0, -1, -1, -1));
		directed_rows[4]  = known_row(qry_beat(0), 1'b0, 0, 0);      // zero-length sequence
		directed_rows[5]  = cfg_row(CFG_SEQ_LENGTH, 65535);
		directed_rows[6]  = known_row(qry_beat(0), 1'b1, 0, 65534);
		directed_rows[7]  = cfg_row(CFG_SEGMENT_COUNT, 64);
		directed_rows[8]  = beat_row(wr_beat(0, 1023, 1023, 4095, 4095, 4095,
		                                     65535, 65535, 65535));
		directed_rows[9]  = beat_row(wr_beat(64, 1023, 1023, 4095, 0, 4095, 0, 0, 0));
		directed_rows[10] = beat_row(qry_beat(0));
		directed_rows[11] = beat_row(qry_beat(63));
		directed_rows[12] = beat_row(qry_beat(32));
		directed_rows[13] = known_row(qry_beat(64), 1'b0, 0, 0);
		directed_rows[14] = beat_row(wr_beat(100, 1023, 1023, 4095, 4095, 4095,
		                                     65535, 65535, 65535));   // ignored
		directed_rows[15] = beat_row(wr_beat(127, 1023, 1023, 4095, 4095, 4095, -1, -1, -1));
		directed_rows[16] = beat_row(qry_beat(1));
		directed_rows[17] = cfg_row(CFG_SEGMENT_COUNT, 127);         // clipped to table size
		directed_rows[18] = beat_row(qry_beat(63));
		directed_rows[19] = known_row(qry_beat(64), 1'b0, 0, 0);
		directed_rows[20] = cfg_row(CFG_SEGMENT_COUNT, 0);
		directed_rows[21] = known_row(qry_beat(0), 1'b0, 0, 0);
		directed_rows[22] = cfg_row(CFG_SEQ_LENGTH, 500);
		directed_rows[23] = cfg_row(CFG_SEGMENT_COUNT, 3);
		// zero constraints: ignored in the walks, binding on the queried segment
		directed_rows[24] = beat_row(wr_beat(1, 2, 3, 5, 4, 9, 0, 0, -1));
		directed_rows[25] = beat_row(wr_beat(0, 1, 1, 2, 1, 3, 10, 20, 40));
		directed_rows[26] = beat_row(qry_beat(1));
		directed_rows[27] = beat_row(qry_beat(2));
		directed_rows[28] = beat_row(qry_beat(0));
		directed_rows[29] = beat_row(wr_beat(2, 4, 4, 6, 2, 12, -1, -1, 300));
		directed_rows[30] = beat_row(qry_beat(1));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every segment and loop row gets written before any query reads it
		for (int i = 0; i <= MAX_SEG; i++) begin
			issue(gen_entry(i), 1'b0, '0);
			pace();
		end

		for (int k = 0; k < NUM_DIR; k++) begin
			if (directed_rows[k].is_cfg) begin
				quiesce();
				cfg_write(directed_rows[k].reg_sel, int'(directed_rows[k].reg_val));
			end else begin
				issue(directed_rows[k].b, directed_rows[k].known, directed_rows[k].want);
				pace();
			end
		end

		// random phases, one register setting each
		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			case (p)
				0: begin
					cfg_write(CFG_SEQ_LENGTH, 3000);
					cfg_write(CFG_SEGMENT_COUNT, 8);
				end
				1: begin
					cfg_write(CFG_SEQ_LENGTH, 65535);
					cfg_write(CFG_SEGMENT_COUNT, 64);
				end
				2: begin
					cfg_write(CFG_SEQ_LENGTH, 0);
					cfg_write(CFG_SEGMENT_COUNT, 1);
				end
				3: begin
					cfg_write(CFG_SEQ_LENGTH, int'($urandom_range(200, 6000)));
					cfg_write(CFG_SEGMENT_COUNT, int'($urandom_range(2, 16)));
				end
				4: begin
					cfg_write(CFG_SEQ_LENGTH, int'($urandom_range(0, 65535)));
					cfg_write(CFG_SEGMENT_COUNT, 100);
				end
				5: begin
					cfg_write(CFG_SEQ_LENGTH, int'($urandom_range(100, 2000)));
					cfg_write(CFG_SEGMENT_COUNT, 0);
				end
				6: begin
					cfg_write(CFG_SEQ_LENGTH, int'($urandom_range(0, 65535)));
					cfg_write(CFG_SEGMENT_COUNT, int'($urandom_range(1, 64)));
				end
				default: begin
					cfg_write(CFG_SEQ_LENGTH, 65535);
					cfg_write(CFG_SEGMENT_COUNT, int'($urandom_range(2, 12)));
				end
			endcase
			nsc = (seg_count_reg > MAX_SEG) ? MAX_SEG : int'(seg_count_reg);
			// long receiver hold-off while beats keep coming: fills the block
			if (p == 0) hold_req = HOLD_LEN;
			for (int k = 0; k < PHASE_LEN; k++) begin
				if (p == 3 && k == 40) begin
					@(negedge clk);
					in_valid = 1'b0;
					drain();
				end
				issue(gen_beat(nsc), 1'b0, '0);
				pace();
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		drain();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
